// ----- rtl/mtrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mtrs_pkg
// Shared types, constants and helpers of the multichannel trial ring store.
// ----------------------------------------------------------------------------
package mtrs_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_SAMPLES  = 256;
    localparam int DEF_MAX_TRIALS   = 32;

    // field widths of the command and result words
    localparam int FUNC_W  = 2;
    localparam int CHAN_W  = 3;
    localparam int TRIAL_W = 6;
    localparam int SIDX_W  = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int NCH_REG_W  = 4;
    localparam int NS_REG_W   = 9;
    localparam int MT_REG_W   = 6;

    localparam logic [NCH_REG_W-1:0] NCH_RESET = 4'd8;
    localparam logic [NS_REG_W-1:0]  NS_RESET  = 9'd256;
    localparam logic [MT_REG_W-1:0]  MT_RESET  = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIALS   = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 2'd0,
        FN_READ   = 2'd1,
        FN_MINMAX = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    // one word in flight alongside the RAM read
    typedef struct packed {
        logic                valid;
        t_func               op;
        logic                status;
        logic                first;
        logic                last;
        logic [TRIAL_W-1:0]  stored;
    } t_tok;

    // saturate a register value into 1..hi
    function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
        int unsigned r;
        if (v < 1) begin
            r = 1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/mtrs_ram.sv -----
// ----------------------------------------------------------------------------
// mtrs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mtrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                     i_wdata,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mtrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtrs_ctrl
// Ring pointers, configuration, command decode and scan sequencer; drives
// the sample RAM and issues one token per RAM access.
// ----------------------------------------------------------------------------
module mtrs_ctrl import mtrs_pkg::*; #(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int MAX_TRIALS   = DEF_MAX_TRIALS,
    parameter int ADDR_W       = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_start,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [CHAN_W-1:0]      i_channel,
    input  logic [TRIAL_W-1:0]     i_trial_index,
    input  logic [TRIAL_W-1:0]     i_end_trial,
    input  logic [SIDX_W-1:0]      i_sample_index,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                   i_end_of_trial,
    output logic                   o_busy,
    output logic                   o_ram_we,
    output logic [ADDR_W-1:0]      o_ram_addr,
    output logic [SAMPLE_BITS-1:0] o_ram_wdata,
    output t_tok                   o_tok
);

    localparam int TR_W  = (MAX_TRIALS > 1) ? $clog2(MAX_TRIALS) : 1;
    localparam int CNT_W = $clog2(MAX_TRIALS + 1);
    localparam int PS_W  = CNT_W + 1;
    localparam int SM_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SN_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CHN_W = $clog2(MAX_CHANNELS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [NCH_REG_W-1:0]  r_num_channels;
    logic [NS_REG_W-1:0]   r_num_samples;
    logic [MT_REG_W-1:0]   r_max_trials;
    logic [TR_W-1:0]       r_ws, n_ws;
    logic [TR_W-1:0]       r_oldest, n_oldest;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CHAN_W-1:0]     r_ch, n_ch;
    logic [TR_W-1:0]       r_slot, n_slot;
    logic [SM_W-1:0]       r_s, n_s;
    logic [TRIAL_W-1:0]    r_t, n_t;
    logic [TRIAL_W-1:0]    r_end, n_end;
    t_tok                  r_tok, n_tok;

    logic [CHN_W-1:0]      nch;
    logic [SN_W-1:0]       ns;
    logic [CNT_W-1:0]      mt;
    logic                  accept;
    t_func                 func;
    logic                  ch_ok, s_ok, mm_ok;
    logic [TRIAL_W-1:0]    end_mm;
    logic [PS_W-1:0]       psum;
    logic [TR_W-1:0]       phys;
    logic [CHAN_W-1:0]     cur_ch;
    logic [TR_W-1:0]       cur_slot;
    logic [SM_W-1:0]       cur_s;
    logic [TRIAL_W-1:0]    cur_t, cur_end;
    logic                  last_s, last_t;

    function automatic logic [TR_W-1:0] inc_slot(input logic [TR_W-1:0] s,
                                                 input logic [CNT_W-1:0] m);
        logic [TR_W-1:0] r;
        if (CNT_W'(s) + CNT_W'(1) == m) begin
            r = '0;
        end else begin
            r = s + TR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CHAN_W-1:0] c,
                                                  input logic [TR_W-1:0]   sl,
                                                  input logic [SM_W-1:0]   s);
        return ADDR_W'(c * (MAX_TRIALS * MAX_SAMPLES) + sl * MAX_SAMPLES + s);
    endfunction

    assign nch    = CHN_W'(clamp_cfg(32'(r_num_channels), MAX_CHANNELS));
    assign ns     = SN_W'(clamp_cfg(32'(r_num_samples), MAX_SAMPLES));
    assign mt     = CNT_W'(clamp_cfg(32'(r_max_trials), MAX_TRIALS));
    assign o_busy = (r_state == ST_SCAN);
    assign accept = i_start && (r_state == ST_IDLE);
    assign func   = t_func'(i_func);
    assign o_tok  = r_tok;

    always_comb begin
        ch_ok  = (i_channel < nch);
        s_ok   = (i_sample_index < ns);
        end_mm = (i_end_trial < r_count) ? i_end_trial : TRIAL_W'(r_count);
        mm_ok  = ch_ok && (i_trial_index < end_mm);
        // logical trial to slot: one wrap at most, as oldest < mt and index < count
        psum   = PS_W'(r_oldest) + PS_W'(i_trial_index);
        phys   = (psum >= PS_W'(mt)) ? TR_W'(psum - PS_W'(mt)) : TR_W'(psum);

        if (r_state == ST_SCAN) begin
            cur_ch   = r_ch;
            cur_slot = r_slot;
            cur_s    = r_s;
            cur_t    = r_t;
            cur_end  = r_end;
        end else begin
            cur_ch   = i_channel;
            cur_slot = phys;
            cur_s    = '0;
            cur_t    = i_trial_index;
            cur_end  = end_mm;
        end
        last_s = (SN_W'(cur_s) + SN_W'(1)) == ns;
        last_t = ({1'b0, cur_t} + (TRIAL_W+1)'(1)) == {1'b0, cur_end};
    end

    always_comb begin
        n_state     = r_state;
        n_ws        = r_ws;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_ch        = cur_ch;
        n_end       = cur_end;
        n_slot      = r_slot;
        n_s         = r_s;
        n_t         = r_t;
        n_tok       = '0;
        n_tok.op    = FN_WRITE;
        o_ram_we    = 1'b0;
        o_ram_addr  = addr_of(cur_ch, cur_slot, cur_s);
        o_ram_wdata = i_sample_value;

        // step the scan position (sample fastest, then trial)
        if (last_s) begin
            n_s    = '0;
            n_t    = cur_t + TRIAL_W'(1);
            n_slot = inc_slot(cur_slot, mt);
        end else begin
            n_s    = cur_s + SM_W'(1);
            n_t    = cur_t;
            n_slot = cur_slot;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_tok.valid = 1'b1;
                    n_tok.op    = func;
                    n_tok.last  = 1'b1;
                    unique case (func)
                        FN_WRITE: begin
                            if (ch_ok && s_ok) begin
                                o_ram_we   = 1'b1;
                                o_ram_addr = addr_of(i_channel, r_ws, SM_W'(i_sample_index));
                                if (i_end_of_trial) begin
                                    n_ws = inc_slot(r_ws, mt);
                                    if (r_count < mt) begin
                                        n_count = r_count + CNT_W'(1);
                                    end else begin
                                        n_oldest = inc_slot(r_oldest, mt);
                                    end
                                end
                            end else begin
                                n_tok.status = 1'b1;
                            end
                        end
                        FN_READ: begin
                            o_ram_addr   = addr_of(i_channel, phys, SM_W'(i_sample_index));
                            n_tok.status = !(ch_ok && s_ok && (i_trial_index < r_count));
                        end
                        FN_MINMAX: begin
                            if (mm_ok) begin
                                n_tok.first = 1'b1;
                                n_tok.last  = last_s && last_t;
                                if (!(last_s && last_t)) begin
                                    n_state = ST_SCAN;
                                end
                            end else begin
                                n_tok.status = 1'b1;
                            end
                        end
                        FN_CLEAR: begin
                            n_ws     = '0;
                            n_oldest = '0;
                            n_count  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                n_tok.valid = 1'b1;
                n_tok.op    = FN_MINMAX;
                n_tok.last  = last_s && last_t;
                if (last_s && last_t) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // any register write empties the ring
        if (i_cfg_we && (i_cfg_index == CFG_NUM_CHANNELS || i_cfg_index == CFG_NUM_SAMPLES
                         || i_cfg_index == CFG_MAX_TRIALS)) begin
            n_ws     = '0;
            n_oldest = '0;
            n_count  = '0;
        end
        n_tok.stored = TRIAL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_ws           <= '0;
            r_oldest       <= '0;
            r_count        <= '0;
            r_tok          <= '0;
            r_num_channels <= NCH_RESET;
            r_num_samples  <= NS_RESET;
            r_max_trials   <= MT_RESET;
        end else begin
            r_state  <= n_state;
            r_ws     <= n_ws;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_tok    <= n_tok;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NUM_CHANNELS: r_num_channels <= i_cfg_data[NCH_REG_W-1:0];
                    CFG_NUM_SAMPLES:  r_num_samples  <= i_cfg_data[NS_REG_W-1:0];
                    CFG_MAX_TRIALS:   r_max_trials   <= i_cfg_data[MT_REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // scan position: payload, no reset
    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_end  <= n_end;
        r_slot <= n_slot;
        r_s    <= n_s;
        r_t    <= n_t;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mt)
        else $error("stored count exceeds ring depth");

    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_ram_we)
        else $error("RAM write during scan");

    a_full_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == mt) |-> (r_ws == r_oldest))
        else $error("full ring with write slot off the oldest trial");

endmodule

// ----- rtl/mtrs_reduce.sv -----
// ----------------------------------------------------------------------------
// mtrs_reduce
// Takes RAM read data with its token, folds min/max over a scan and
// registers the result word.
// ----------------------------------------------------------------------------
module mtrs_reduce import mtrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tok                   i_tok,
    input  logic [SAMPLE_BITS-1:0] i_rdata,
    output logic                   o_done,
    output logic                   o_status,
    output logic [SAMPLE_BITS-1:0] o_read_value,
    output logic [SAMPLE_BITS-1:0] o_min_value,
    output logic [SAMPLE_BITS-1:0] o_max_value,
    output logic [TRIAL_W-1:0]     o_stored_trials
);

    logic                   r_done, n_done;
    logic                   r_status;
    logic [SAMPLE_BITS-1:0] r_read, n_read;
    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [TRIAL_W-1:0]     r_stored;
    logic [SAMPLE_BITS-1:0] r_acc_min, r_acc_max;
    logic [SAMPLE_BITS-1:0] cand_min, cand_max;
    logic                   scan_ok;

    always_comb begin
        scan_ok = i_tok.valid && (i_tok.op == FN_MINMAX) && !i_tok.status;
        if (i_tok.first) begin
            cand_min = i_rdata;
            cand_max = i_rdata;
        end else begin
            cand_min = ($signed(i_rdata) < $signed(r_acc_min)) ? i_rdata : r_acc_min;
            cand_max = ($signed(i_rdata) > $signed(r_acc_max)) ? i_rdata : r_acc_max;
        end
        // hold the word back until the last sample of a scan
        n_done = i_tok.valid && !(scan_ok && !i_tok.last);
        n_read = (i_tok.op == FN_READ && !i_tok.status) ? i_rdata : '0;
        n_min  = scan_ok ? cand_min : '0;
        n_max  = scan_ok ? cand_max : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_ok) begin
            r_acc_min <= cand_min;
            r_acc_max <= cand_max;
        end
        if (n_done) begin
            r_status <= i_tok.status;
            r_read   <= n_read;
            r_min    <= n_min;
            r_max    <= n_max;
            r_stored <= i_tok.stored;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_value    = r_read;
    assign o_min_value     = r_min;
    assign o_max_value     = r_max;
    assign o_stored_trials = r_stored;

    a_done_has_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_tok.valid))
        else $error("result word without a token");

endmodule

// ----- rtl/multichannel_trial_ring_store.sv -----
// ----------------------------------------------------------------------------
// multichannel_trial_ring_store
// Ring of the newest trials of multichannel samples, with sample write, read,
// per-channel min/max over a trial range, and clear.
//
//   channel   direction  handshake              payload
//   command   in         start & !busy          i_func .. i_end_of_trial
//   result    out        o_done (one cycle)     o_status .. o_stored_trials
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// Write, read and clear leave busy low; the result passes the token register
// and then the result register after acceptance, and a new command is taken
// every cycle while busy is low. Min/max reads one sample per cycle from the
// single RAM port: busy stays high until the final read is issued, and the
// result passes the token and result registers after that read.
// Reset clears pointers and registers only; the sample RAM is not swept.
// The result cannot be stalled: o_done marks it for exactly one cycle.
// ----------------------------------------------------------------------------
module multichannel_trial_ring_store import mtrs_pkg::*; #(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int MAX_TRIALS   = DEF_MAX_TRIALS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [CHAN_W-1:0]      i_channel,
    input  logic [TRIAL_W-1:0]     i_trial_index,
    input  logic [TRIAL_W-1:0]     i_end_trial,
    input  logic [SIDX_W-1:0]      i_sample_index,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                   i_end_of_trial,
    output logic                   o_done,
    output logic                   o_status,
    output logic [SAMPLE_BITS-1:0] o_read_value,
    output logic [SAMPLE_BITS-1:0] o_min_value,
    output logic [SAMPLE_BITS-1:0] o_max_value,
    output logic [TRIAL_W-1:0]     o_stored_trials
);

    localparam int DEPTH  = MAX_CHANNELS * MAX_TRIALS * MAX_SAMPLES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    t_tok                   tok;

    mtrs_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_TRIALS   (MAX_TRIALS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_func         (i_func),
        .i_channel      (i_channel),
        .i_trial_index  (i_trial_index),
        .i_end_trial    (i_end_trial),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_end_of_trial (i_end_of_trial),
        .o_busy         (busy),
        .o_ram_we       (ram_we),
        .o_ram_addr     (ram_addr),
        .o_ram_wdata    (ram_wdata),
        .o_tok          (tok)
    );

    mtrs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    mtrs_reduce u_reduce (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok           (tok),
        .i_rdata         (ram_rdata),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_min_value     (o_min_value),
        .o_max_value     (o_max_value),
        .o_stored_trials (o_stored_trials)
    );

endmodule
